@@ design/pfl_pkg.sv @@
// Shared types and constants for the palette fade lookup unit.
`timescale 1ns / 1ps

package pfl_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;
   localparam int CHAN_W = 8;
   localparam int COLOR_W = 3 * CHAN_W;
   // ceil(2^16 / s) is exact for 8-bit targets; s = 1 needs the 17th bit
   localparam int RECIP_SHIFT = 2 * CHAN_W;
   localparam int RECIP_W = RECIP_SHIFT + 1;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [RECIP_W-1:0] recip_type;

   typedef enum logic [2:0] {
      OP_LOAD     = 3'd0,
      OP_FADE_IN  = 3'd1,
      OP_FADE_OUT = 3'd2,
      OP_TICK     = 3'd3,
      OP_LOOKUP   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      MODE_BLACK  = 2'd0,
      MODE_TARGET = 2'd1,
      MODE_SCALED = 2'd2
   } mode_type;

endpackage

@@ design/pfl_recip.sv @@
// Iterative reciprocal unit: computes ceil(2^16 / divisor), one quotient bit per cycle.
`timescale 1ns / 1ps

module pfl_recip (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pfl_pkg::chan_type divisor,
   output logic              done,
   output pfl_pkg::recip_type recip
);
   import pfl_pkg::*;

   localparam int CNT_W = $clog2(RECIP_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   chan_type            div_ff, div_in;
   chan_type            rem_ff, rem_in;
   recip_type           num_ff, num_in;   // dividend shifts out, quotient shifts in

   logic [CHAN_W:0]     rem_shift;
   logic [CHAN_W:0]     rem_diff;
   logic                take;

   always_comb begin
      rem_shift = {rem_ff, num_ff[RECIP_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      take      = (rem_shift >= {1'b0, div_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;

      if (start) begin
         // ceil(2^16/d) = floor((2^16 - 1 + d) / d)
         busy_in = 1'b1;
         cnt_in  = CNT_W'(RECIP_W);
         div_in  = divisor;
         rem_in  = '0;
         num_in  = RECIP_W'((1 << RECIP_SHIFT) - 1) + RECIP_W'(divisor);
      end else if (busy_ff) begin
         rem_in = take ? rem_diff[CHAN_W-1:0] : rem_shift[CHAN_W-1:0];
         num_in = {num_ff[RECIP_W-2:0], take};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         div_ff  <= div_in;
         rem_ff  <= rem_in;
         num_ff  <= num_in;
      end
   end

   assign done  = done_ff;
   assign recip = num_ff;

endmodule

@@ design/palette_fade_lookup_unit.sv @@
// Palette fade lookup unit: top level with palette memory, fade state and lookup datapath.
`timescale 1ns / 1ps

// Holds a palette of PALETTE_ENTRIES 24-bit target colors in a single-port-write,
// registered-read memory and answers one item at a time, one result per item.
// Load, tick and unknown operations go from accept through the done state back to idle.
// A lookup issues the memory read in the accept cycle; the read state registers the
// target, the scale state computes floor(target/steps) as a multiply by a stored
// reciprocal, and the done state multiplies by the fade step into the output register.
// A fade start waits in the recip state for the iterative reciprocal unit, which
// produces one of 17 quotient bits per cycle; that reciprocal is then reused by
// every lookup of the fade. A finished result waits in the output register while
// the next item is accepted. Entries never loaded read back undefined.
module palette_fade_lookup_unit #(
   parameter int PALETTE_ENTRIES = pfl_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_operation,
   input  pfl_pkg::chan_type req_index,
   input  pfl_pkg::chan_type req_red,
   input  pfl_pkg::chan_type req_green,
   input  pfl_pkg::chan_type req_blue,
   input  pfl_pkg::chan_type req_ramp_len,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pfl_pkg::chan_type rsp_out_red,
   output pfl_pkg::chan_type rsp_out_green,
   output pfl_pkg::chan_type rsp_out_blue,
   output logic              rsp_is_fading
);
   import pfl_pkg::*;

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam int PROD_W = CHAN_W + RECIP_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RECIP,
      S_READ,
      S_SCALE,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   chan_type               step_total_ff, step_total_in;
   chan_type               step_count_ff, step_count_in;
   logic                   fade_active_ff, fade_active_in;
   logic                   fade_up_ff, fade_up_in;
   mode_type               mode_ff, mode_in;
   logic                   in_range_ff, in_range_in;
   logic [2:0][CHAN_W-1:0] tgt_ff, tgt_in;
   logic [2:0][CHAN_W-1:0] quot_ff, quot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0][CHAN_W-1:0] rsp_color_ff, rsp_color_in;
   logic                   rsp_fading_ff, rsp_fading_in;

   logic [COLOR_W-1:0]     target_mem [PALETTE_ENTRIES];
   logic [COLOR_W-1:0]     rd_data_ff;
   logic                   mem_we;
   logic                   mem_re;
   logic [AW-1:0]          mem_addr;
   logic                   idx_in_range;

   logic                   recip_start;
   logic                   recip_done;
   recip_type              recip;

   chan_type               step_next;
   chan_type               k_factor;
   logic [PROD_W-1:0]      quot_prod [3];
   logic [2*CHAN_W-1:0]    scale_prod [3];
   logic [2:0][CHAN_W-1:0] shown_color;

   pfl_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (recip_start),
      .divisor (req_ramp_len),
      .done    (recip_done),
      .recip   (recip)
   );

   assign req_ready    = (state_ff == S_IDLE);
   assign idx_in_range = ({1'b0, req_index} < (CHAN_W + 1)'(PALETTE_ENTRIES));
   assign mem_addr     = req_index[AW-1:0];
   assign step_next    = step_count_ff + chan_type'(1);
   assign k_factor     = fade_up_ff ? step_count_ff : (step_total_ff - step_count_ff);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         quot_prod[c]  = PROD_W'(tgt_ff[c]) * PROD_W'(recip);
         scale_prod[c] = (2*CHAN_W)'(quot_ff[c]) * (2*CHAN_W)'(k_factor);
      end
   end

   // shown color of the entry being looked up, taken into the output register in S_DONE
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         case (mode_ff)
            MODE_BLACK:  shown_color[c] = '0;
            MODE_TARGET: shown_color[c] = tgt_ff[c];
            MODE_SCALED: shown_color[c] = (step_total_ff == '0) ? '0 :
                                          scale_prod[c][CHAN_W-1:0];
            default:     shown_color[c] = '0;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_total_in  = step_total_ff;
      step_count_in  = step_count_ff;
      fade_active_in = fade_active_ff;
      fade_up_in     = fade_up_ff;
      mode_in        = mode_ff;
      in_range_in    = in_range_ff;
      tgt_in         = tgt_ff;
      quot_in        = quot_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_color_in   = rsp_color_ff;
      rsp_fading_in  = rsp_fading_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      recip_start    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               in_range_in = 1'b0;
               state_in    = S_DONE;
               case (op_type'(req_operation))
                  OP_LOAD: begin
                     mem_we         = idx_in_range;
                     mode_in        = MODE_TARGET;
                     fade_active_in = 1'b0;
                  end
                  OP_FADE_IN, OP_FADE_OUT: begin
                     step_total_in  = req_ramp_len;
                     step_count_in  = '0;
                     fade_active_in = 1'b1;
                     fade_up_in     = (op_type'(req_operation) == OP_FADE_IN);
                     mode_in        = (op_type'(req_operation) == OP_FADE_IN) ?
                                      MODE_BLACK : MODE_TARGET;
                     recip_start    = 1'b1;
                     state_in       = S_RECIP;
                  end
                  OP_TICK: begin
                     if (fade_active_ff) begin
                        step_count_in = step_next;
                        if (step_next >= step_total_ff) begin
                           fade_active_in = 1'b0;
                           mode_in        = fade_up_ff ? MODE_TARGET : MODE_BLACK;
                        end else begin
                           mode_in = MODE_SCALED;
                        end
                     end
                  end
                  OP_LOOKUP: begin
                     mem_re      = 1'b1;
                     in_range_in = idx_in_range;
                     state_in    = S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RECIP: begin
            if (recip_done) begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            tgt_in   = rd_data_ff;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            for (int c = 0; c < 3; c++) begin
               quot_in[c] = quot_prod[c][RECIP_SHIFT +: CHAN_W];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // in_range_ff is set only for an in-range lookup; every other item answers zero
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_fading_in = fade_active_ff;
               rsp_color_in  = in_range_ff ? shown_color : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         target_mem[mem_addr] <= {req_red, req_green, req_blue};
      end
      if (mem_re) begin
         rd_data_ff <= target_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         step_total_ff  <= '0;
         step_count_ff  <= '0;
         fade_active_ff <= 1'b0;
         fade_up_ff     <= 1'b0;
         mode_ff        <= MODE_BLACK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_total_ff  <= step_total_in;
         step_count_ff  <= step_count_in;
         fade_active_ff <= fade_active_in;
         fade_up_ff     <= fade_up_in;
         mode_ff        <= mode_in;
         rsp_valid_ff   <= rsp_valid_in;
         in_range_ff    <= in_range_in;
         tgt_ff         <= tgt_in;
         quot_ff        <= quot_in;
         rsp_color_ff   <= rsp_color_in;
         rsp_fading_ff  <= rsp_fading_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_color_ff[2];
   assign rsp_out_green = rsp_color_ff[1];
   assign rsp_out_blue  = rsp_color_ff[0];
   assign rsp_is_fading = rsp_fading_ff;

`ifndef NO_ASSERTIONS
   a_scaled_needs_fade: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_SCALED) |-> (fade_active_ff && step_total_ff >= chan_type'(2)))
      else $error("scaled mode outside a fade of at least two steps");

   a_count_below_total: assert property (@(posedge clock) disable iff (reset)
      (fade_active_ff && step_count_ff != '0) |-> (step_count_ff < step_total_ff))
      else $error("fade step counter reached the step count while fading");

   a_recip_done_waited: assert property (@(posedge clock) disable iff (reset)
      recip_done |-> (state_ff == S_RECIP))
      else $error("reciprocal finished while no fade start was waiting");

   a_lookup_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_SCALE) ##1 (state_ff == S_DONE))
      else $error("lookup did not pass through read, scale and done in order");
`endif

endmodule
